// ----- hdl/ghmt_pkg.sv -----
// shared types and codes of the gossip heartbeat membership table
package ghmt_pkg;

    localparam int DEF_MAX_MEMBERS = 64;

    localparam logic [2:0] MODE_JOIN   = 3'd0;
    localparam logic [2:0] MODE_SENDER = 3'd1;
    localparam logic [2:0] MODE_GOSSIP = 3'd2;
    localparam logic [2:0] MODE_TICK   = 3'd3;
    localparam logic [2:0] MODE_LIST   = 3'd4;

    localparam logic [2:0] EV_ADDED   = 3'd1;
    localparam logic [2:0] EV_REMOVED = 3'd2;
    localparam logic [2:0] EV_LIVE    = 3'd3;
    localparam logic [2:0] EV_FULL    = 3'd4;

    localparam logic [1:0] REG_SELF_ID   = 2'd0;
    localparam logic [1:0] REG_SELF_PORT = 2'd1;
    localparam logic [1:0] REG_FAIL      = 2'd2;
    localparam logic [1:0] REG_REMOVE    = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] now;
        logic [31:0] node_id;
        logic [15:0] node_port;
        logic [31:0] entry_heartbeat;
    } t_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [31:0] out_id;
        logic [15:0] out_port;
        logic [31:0] out_heartbeat;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] beat;
        logic [31:0] stamp;
    } t_entry;

endpackage

// ----- hdl/ghmt_table.sv -----
// member table storage with per-slot valid bits and registered read
module ghmt_table import ghmt_pkg::*; #(
    parameter int Depth = DEF_MAX_MEMBERS,
    localparam int Aw = $clog2(Depth)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [Aw-1:0] i_waddr,
    input  logic          i_wvalid,
    input  t_entry        i_wdata,
    input  logic [Aw-1:0] i_raddr,
    output logic          o_rvalid,
    output t_entry        o_rdata
);

    logic [Depth-1:0] r_valid;
    t_entry           r_mem [Depth];
    logic             r_rvalid;
    t_entry           r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= i_wvalid;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rvalid = r_rvalid;
    assign o_rdata  = r_rdata;

endmodule

// ----- hdl/gossip_heartbeat_membership_table_core.sv -----
// gossip heartbeat membership table: sequencer, config registers and result path
// Every command walks the whole table one slot per cycle through a single read and
// write port, so one item keeps busy high through the walk, the tail and the flush, whatever its
// mode. Results appear during the walk and after it, at most one per cycle, each
// strobed for exactly one cycle with no way to hold them off; the final beat of an
// item carries last. Nothing is reported for an item that has no event.
module gossip_heartbeat_membership_table_core import ghmt_pkg::*; #(
    parameter int MAX_MEMBERS = DEF_MAX_MEMBERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_result_strobe,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int Aw = $clog2(MAX_MEMBERS);
    localparam int Cw = Aw + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_TAIL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [Cw-1:0] r_cnt, n_cnt;
    t_item         r_item, n_item;
    logic          r_found, n_found;
    logic          r_have_free, n_have_free;
    logic [Aw-1:0] r_free_idx, n_free_idx;
    logic          r_pend, n_pend;
    t_result       r_pend_ev, n_pend_ev;
    logic [31:0]   r_own, n_own;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic [31:0] r_self_id;
    logic [15:0] r_self_port;
    logic [15:0] r_fail;
    logic [15:0] r_remove;

    logic          we, wvalid, rd_valid;
    logic [Aw-1:0] waddr, e_idx;
    t_entry        wdata, rd;
    logic [31:0]   key_id, age;
    logic [15:0]   key_port;
    logic          match, evict, live, ev_hit;
    t_result       ev;

    ghmt_table #(.Depth(MAX_MEMBERS)) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wvalid (wvalid),
        .i_wdata  (wdata),
        .i_raddr  (r_cnt[Aw-1:0]),
        .o_rvalid (rd_valid),
        .o_rdata  (rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_id   <= 32'd1;
            r_self_port <= 16'd0;
            r_fail      <= 16'd5;
            r_remove    <= 16'd20;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_SELF_ID:   r_self_id   <= pwdata;
                REG_SELF_PORT: r_self_port <= pwdata[15:0];
                REG_FAIL:      r_fail      <= pwdata[15:0];
                REG_REMOVE:    r_remove    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SELF_ID:   prdata = r_self_id;
            REG_SELF_PORT: prdata = {16'd0, r_self_port};
            REG_FAIL:      prdata = {16'd0, r_fail};
            REG_REMOVE:    prdata = {16'd0, r_remove};
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign e_idx    = Aw'(r_cnt - Cw'(1));
    assign key_id   = (r_item.mode == MODE_TICK) ? r_self_id : r_item.node_id;
    assign key_port = (r_item.mode == MODE_TICK) ? r_self_port : r_item.node_port;
    assign match    = rd_valid && rd.id == key_id && rd.port == key_port;
    assign age      = r_item.now - rd.stamp;
    assign evict    = rd_valid && age > {16'd0, r_remove};
    assign live     = rd_valid && age < {16'd0, r_fail};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_item      = r_item;
        n_found     = r_found;
        n_have_free = r_have_free;
        n_free_idx  = r_free_idx;
        n_pend      = r_pend;
        n_pend_ev   = r_pend_ev;
        n_own       = r_own;
        n_out_valid = 1'b0;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = e_idx;
        wvalid      = 1'b1;
        wdata       = rd;
        ev_hit      = 1'b0;
        ev          = '{event_kind: EV_ADDED, out_id: rd.id, out_port: rd.port,
                        out_heartbeat: rd.beat, last: 1'b0};
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_item      = i_item;
                    n_cnt       = '0;
                    n_found     = 1'b0;
                    n_have_free = 1'b0;
                    n_pend      = 1'b0;
                    if (i_item.mode == MODE_TICK) begin
                        n_own = r_own + 32'd1;
                    end
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + Cw'(1);
                if (r_cnt != '0) begin
                    // free slot seen so far, counting slots evicted on this pass
                    if (!r_have_free && (!rd_valid ||
                            (r_item.mode == MODE_TICK && evict &&
                             !(match && !r_found)))) begin
                        n_have_free = 1'b1;
                        n_free_idx  = e_idx;
                    end
                    case (r_item.mode)
                        MODE_SENDER: begin
                            if (match) begin
                                we         = 1'b1;
                                wdata.beat  = rd.beat + 32'd1;
                                wdata.stamp = r_item.now;
                            end
                        end
                        MODE_GOSSIP: begin
                            if (match && !r_found) begin
                                n_found = 1'b1;
                                if (r_item.entry_heartbeat > rd.beat) begin
                                    we          = 1'b1;
                                    wdata.beat  = r_item.entry_heartbeat;
                                    wdata.stamp = r_item.now;
                                end
                            end
                        end
                        MODE_TICK: begin
                            if (match && !r_found) begin
                                n_found     = 1'b1;
                                we          = 1'b1;
                                wdata.beat  = r_own;
                                wdata.stamp = r_item.now;
                            end else if (evict) begin
                                we            = 1'b1;
                                wvalid        = 1'b0;
                                ev_hit        = 1'b1;
                                ev.event_kind = EV_REMOVED;
                            end
                        end
                        MODE_LIST: begin
                            if (live) begin
                                ev_hit        = 1'b1;
                                ev.event_kind = EV_LIVE;
                            end
                        end
                        default: ;
                    endcase
                end
                if (r_cnt == Cw'(MAX_MEMBERS)) begin
                    n_state = ST_TAIL;
                end
            end
            ST_TAIL: begin
                waddr       = r_free_idx;
                wdata.id    = key_id;
                wdata.port  = key_port;
                wdata.stamp = r_item.now;
                wdata.beat  = (r_item.mode == MODE_GOSSIP) ? r_item.entry_heartbeat :
                              (r_item.mode == MODE_TICK) ? r_own : 32'd0;
                ev.out_id        = key_id;
                ev.out_port      = key_port;
                ev.out_heartbeat = wdata.beat;
                if ((r_item.mode == MODE_JOIN || r_item.mode == MODE_GOSSIP ||
                        r_item.mode == MODE_TICK) && !r_found) begin
                    if (r_have_free) begin
                        we = 1'b1;
                        if (r_item.mode != MODE_TICK) begin
                            ev_hit        = 1'b1;
                            ev.event_kind = EV_ADDED;
                        end
                    end else begin
                        ev_hit        = 1'b1;
                        ev.event_kind = EV_FULL;
                    end
                end
                n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (r_pend) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend_ev;
                    n_out.last  = 1'b1;
                end
                n_pend  = 1'b0;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        // hold one event back so the final beat can carry last
        if (ev_hit) begin
            if (r_pend) begin
                n_out_valid = 1'b1;
                n_out       = r_pend_ev;
            end
            n_pend    = 1'b1;
            n_pend_ev = ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
            r_pend      <= 1'b0;
            r_own       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_found     <= n_found;
            r_have_free <= n_have_free;
            r_pend      <= n_pend;
            r_own       <= n_own;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_free_idx <= n_free_idx;
        r_pend_ev  <= n_pend_ev;
        r_out      <= n_out;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_result_strobe = r_out_valid;
    assign o_result        = r_out;

`ifndef SYNTHESIS
    a_onehot_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    a_beat_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> $past(busy))
        else $error("result beat without an item in progress");
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_result.last) |-> !busy)
        else $error("last beat while item still in progress");
    a_start_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start");
    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !r_pend)
        else $error("held event left behind at idle");
`endif

endmodule

// ----- tb/membership_checker.sv -----
// checker for the membership table: predicts events per accepted command beat and compares
module membership_checker import ghmt_pkg::*; #(
    parameter int MAX_MEMBERS = DEF_MAX_MEMBERS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  t_item       i_item,
    input  logic        o_result_strobe,
    input  t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    logic        slot_used [MAX_MEMBERS];
    t_entry      slot [MAX_MEMBERS];
    logic [31:0] own_beat;
    logic [31:0] self_id;
    logic [15:0] self_port;
    logic [15:0] fail_to;
    logic [15:0] remove_to;
    t_result     event_q [$];
    int          fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = event_q.size();

    function automatic int find_slot(logic [31:0] id, logic [15:0] port);
        for (int i = 0; i < MAX_MEMBERS; i++)
            if (slot_used[i] && slot[i].id == id && slot[i].port == port) return i;
        return -1;
    endfunction

    function automatic bit insert_slot(logic [31:0] id, logic [15:0] port,
                                       logic [31:0] beat, logic [31:0] stamp);
        for (int i = 0; i < MAX_MEMBERS; i++) begin
            if (!slot_used[i]) begin
                slot_used[i] = 1'b1;
                slot[i] = '{id: id, port: port, beat: beat, stamp: stamp};
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic add_event(logic [2:0] kind, logic [31:0] id, logic [15:0] port,
                             logic [31:0] beat);
        t_result ev;
        ev = '{event_kind: kind, out_id: id, out_port: port,
               out_heartbeat: beat, last: 1'b0};
        event_q.insert(event_q.size(), ev);
    endtask

    task automatic predict_events(t_item it);
        int      n0;
        int      idx;
        int      self_idx;
        n0 = event_q.size();
        case (it.mode)
            MODE_JOIN: begin
                if (insert_slot(it.node_id, it.node_port, 32'd0, it.now))
                    add_event(EV_ADDED, it.node_id, it.node_port, 32'd0);
                else
                    add_event(EV_FULL, it.node_id, it.node_port, 32'd0);
            end
            MODE_SENDER: begin
                for (int i = 0; i < MAX_MEMBERS; i++) begin
                    if (slot_used[i] && slot[i].id == it.node_id &&
                        slot[i].port == it.node_port) begin
                        slot[i].beat  = slot[i].beat + 32'd1;
                        slot[i].stamp = it.now;
                    end
                end
            end
            MODE_GOSSIP: begin
                idx = find_slot(it.node_id, it.node_port);
                if (idx >= 0) begin
                    if (it.entry_heartbeat > slot[idx].beat) begin
                        slot[idx].beat  = it.entry_heartbeat;
                        slot[idx].stamp = it.now;
                    end
                end else if (insert_slot(it.node_id, it.node_port, it.entry_heartbeat, it.now))
                    add_event(EV_ADDED, it.node_id, it.node_port, it.entry_heartbeat);
                else
                    add_event(EV_FULL, it.node_id, it.node_port, it.entry_heartbeat);
            end
            MODE_TICK: begin
                own_beat = own_beat + 32'd1;
                self_idx = find_slot(self_id, self_port);
                if (self_idx >= 0) begin
                    slot[self_idx].beat  = own_beat;
                    slot[self_idx].stamp = it.now;
                end
                for (int i = 0; i < MAX_MEMBERS; i++) begin
                    if (slot_used[i] && (it.now - slot[i].stamp) > {16'd0, remove_to}) begin
                        slot_used[i] = 1'b0;
                        add_event(EV_REMOVED, slot[i].id, slot[i].port, slot[i].beat);
                    end
                end
                if (self_idx < 0 && !insert_slot(self_id, self_port, own_beat, it.now))
                    add_event(EV_FULL, self_id, self_port, own_beat);
            end
            MODE_LIST: begin
                for (int i = 0; i < MAX_MEMBERS; i++)
                    if (slot_used[i] && (it.now - slot[i].stamp) < {16'd0, fail_to})
                        add_event(EV_LIVE, slot[i].id, slot[i].port, slot[i].beat);
            end
            default: ;
        endcase
        if (event_q.size() > n0) begin
            event_q[event_q.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_MEMBERS; i++) slot_used[i] = 1'b0;
            own_beat  = 32'd0;
            self_id   = 32'd1;
            self_port = 16'd0;
            fail_to   = 16'd5;
            remove_to = 16'd20;
            event_q.delete();
        end else begin
            if (o_result_strobe) begin
                if (event_q.size() == 0) begin
                    fails++;
                    $display("%0t unexpected beat: got kind %0d id %h port %h beat %h last %b",
                             $time, o_result.event_kind, o_result.out_id, o_result.out_port,
                             o_result.out_heartbeat, o_result.last);
                end else begin
                    t_result exp_r;
                    exp_r = event_q.pop_front();
                    if (exp_r !== o_result) begin
                        fails++;
                        $display("%0t mismatch: expected kind %0d id %h port %h beat %h last %b",
                                 $time, exp_r.event_kind, exp_r.out_id, exp_r.out_port,
                                 exp_r.out_heartbeat, exp_r.last);
                        $display("%0t           actual kind %0d id %h port %h beat %h last %b",
                                 $time, o_result.event_kind, o_result.out_id, o_result.out_port,
                                 o_result.out_heartbeat, o_result.last);
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_SELF_ID:   self_id   = pwdata;
                    REG_SELF_PORT: self_port = pwdata[15:0];
                    REG_FAIL:      fail_to   = pwdata[15:0];
                    REG_REMOVE:    remove_to = pwdata[15:0];
                    default: ;
                endcase
            end
            if (start && !busy) predict_events(i_item);
        end
    end

endmodule

// ----- tb/gossip_heartbeat_membership_table_core_tb.sv -----
// testbench top for the membership table core: stimulus, config phases and verdict
module gossip_heartbeat_membership_table_core_tb;
    import ghmt_pkg::*;

    localparam int MAX_MEMBERS = DEF_MAX_MEMBERS;
    localparam int DRAIN       = MAX_MEMBERS + 80;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int POOL        = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_item       i_item = '0;
    logic        o_result_strobe;
    t_result     o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          cycles = 0;

    logic [31:0] t_now;
    logic [31:0] pool_id [POOL];
    logic [15:0] pool_port [POOL];

    always #2 i_clk = ~i_clk;

    gossip_heartbeat_membership_table_core #(.MAX_MEMBERS(MAX_MEMBERS)) dut (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_result_strobe, .o_result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    membership_checker #(.MAX_MEMBERS(MAX_MEMBERS)) u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_result_strobe, .o_result,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** gossip_heartbeat_membership_table_core: FAILED **");
            $finish;
        end
    end

    task automatic send_cmd(t_item it, bit may_idle);
        logic b;
        start  <= 1'b1;
        i_item <= it;
        do begin
            @(negedge i_clk);
            b = busy;
            @(posedge i_clk);
        end while (b);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic cmd(logic [2:0] mode, logic [31:0] now, logic [31:0] id,
                       logic [15:0] port, logic [31:0] hb);
        send_cmd('{mode: mode, now: now, node_id: id, node_port: port,
                   entry_heartbeat: hb}, 1'b1);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(negedge i_clk);
        @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] sid, logic [15:0] sport,
                              logic [15:0] fail_t, logic [15:0] rem_t);
        wait_idle();
        reg_write(REG_SELF_ID, sid);
        reg_write(REG_SELF_PORT, {16'd0, sport});
        reg_write(REG_FAIL, {16'd0, fail_t});
        reg_write(REG_REMOVE, {16'd0, rem_t});
        pool_id[0]   = sid;
        pool_port[0] = sport;
        @(posedge i_clk);
    endtask

    function automatic t_item rand_cmd(int join_w, bit jumps);
        t_item it;
        int    r;
        int    k;
        r = $urandom_range(0, 99);
        if (r < join_w)                  it.mode = MODE_JOIN;
        else if (r < join_w + 20)        it.mode = MODE_SENDER;
        else if (r < join_w + 42)        it.mode = MODE_GOSSIP;
        else if (r < join_w + 56)        it.mode = MODE_TICK;
        else if (r < 96)                 it.mode = MODE_LIST;
        else                             it.mode = 3'($urandom_range(5, 7));
        if (jumps && $urandom_range(0, 33) == 0) t_now = $urandom;
        else t_now = t_now + 32'($urandom_range(0, 4));
        it.now = t_now;
        k = $urandom_range(0, POOL - 1);
        if ($urandom_range(0, 4) == 0) begin
            it.node_id   = $urandom;
            it.node_port = 16'($urandom);
        end else begin
            it.node_id   = pool_id[k];
            it.node_port = pool_port[k];
        end
        it.entry_heartbeat = $urandom_range(0, 1) ? 32'($urandom_range(0, 20)) : $urandom;
        return it;
    endfunction

    task automatic run_random(int count, int join_w, bit jumps, bit may_idle);
        repeat (count) send_cmd(rand_cmd(join_w, jumps), may_idle);
    endtask

    initial begin
        pool_id[0] = 32'd1;
        pool_port[0] = 16'd0;
        pool_id[1] = 32'd0;
        pool_port[1] = 16'd0;
        pool_id[2] = 32'hFFFF_FFFF;
        pool_port[2] = 16'hFFFF;
        for (int i = 3; i < POOL; i++) begin
            pool_id[i]   = $urandom;
            pool_port[i] = 16'($urandom);
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, self id 1 port 0
        cmd(MODE_JOIN,   32'd100, 32'd0, 16'd0, 32'd0);
        cmd(MODE_JOIN,   32'd100, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        cmd(MODE_JOIN,   32'd100, 32'd0, 16'd0, 32'd0);
        cmd(MODE_SENDER, 32'd101, 32'd0, 16'd0, 32'd0);
        cmd(MODE_SENDER, 32'd101, 32'd5, 16'd5, 32'd0);
        cmd(MODE_GOSSIP, 32'd101, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
        cmd(MODE_GOSSIP, 32'd102, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        cmd(MODE_GOSSIP, 32'd102, 32'h1234_5678, 16'h1234, 32'd7);
        cmd(MODE_LIST,   32'd102, 32'd0, 16'd0, 32'd0);
        cmd(MODE_TICK,   32'd103, 32'd0, 16'd0, 32'd0);
        cmd(MODE_TICK,   32'd104, 32'd0, 16'd0, 32'd0);
        cmd(MODE_LIST,   32'd104, 32'd0, 16'd0, 32'd0);
        cmd(MODE_TICK,   32'd130, 32'd0, 16'd0, 32'd0);
        cmd(3'd5,        32'd131, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        cmd(3'd6,        32'd131, 32'd0, 16'd0, 32'd0);
        cmd(3'd7,        32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        cmd(MODE_JOIN,   32'hFFFF_FFFE, 32'hA5A5_A5A5, 16'h5A5A, 32'd0);
        cmd(MODE_GOSSIP, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 16'hA5A5, 32'h8000_0000);
        cmd(MODE_LIST,   32'd1, 32'd0, 16'd0, 32'd0);
        cmd(MODE_SENDER, 32'd2, 32'hA5A5_A5A5, 16'h5A5A, 32'd0);
        cmd(MODE_TICK,   32'd2, 32'd0, 16'd0, 32'd0);
        cmd(MODE_LIST,   32'd3, 32'd0, 16'd0, 32'd0);

        t_now = 32'd10;
        run_random(90, 25, 1'b1, 1'b1);

        // widest timeouts: table fills and rejects inserts
        set_config(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(100, 40, 1'b0, 1'b1);

        // narrowest timeouts: heavy eviction
        set_config(32'd0, 16'd0, 16'd1, 16'd1);
        run_random(90, 25, 1'b1, 1'b1);

        set_config($urandom, 16'($urandom), 16'($urandom_range(1, 40)),
                   16'($urandom_range(1, 40)));
        run_random(100, 25, 1'b1, 1'b1);

        set_config($urandom, 16'($urandom), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 65535)));
        run_random(40, 25, 1'b1, 1'b1);
        run_random(60, 25, 1'b1, 1'b0);

        wait_idle();
        if (fail_count == 0)
            $display("** gossip_heartbeat_membership_table_core: PASSED **");
        else
            $display("** gossip_heartbeat_membership_table_core: FAILED **");
        $finish;
    end

endmodule
